// File: hw/rtl/positional_list_store_macros.svh
// ------------------------------------------------------------------------
// Assertion macros for the positional list store checker.
// ------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define PLS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define PLS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pls_pkg.sv
// ------------------------------------------------------------------------
// pls_pkg
// Types and constants shared by the positional list store modules.
// ------------------------------------------------------------------------
package pls_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned OP_W         = 3;
  localparam int unsigned POS_W        = 8;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CNT_W        = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_BACK  = 3'd4,
    OP_REM_AT    = 3'd5,
    OP_DUMP      = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_EMPTY = 2'd2,
    STS_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic        [OP_W-1:0]   op;
    logic signed [POS_W-1:0]  position;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic        [1:0]        status;
    logic signed [DATA_W-1:0] element;
    logic        [CNT_W-1:0]  count;
    logic                     is_empty;
    logic                     last;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic exec;       // input transfer: run the operation
    logic dump_step;  // emit the next dump element
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic dump_more;  // current input is a dump with more than one element
    logic dump_last;  // next dump step emits the final element
  } sts_t;

endpackage

// File: hw/rtl/pls_ctrl.sv
// ------------------------------------------------------------------------
// pls_ctrl
// Sequencer: input acceptance, dump sequencing, output valid.
// ------------------------------------------------------------------------
module pls_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  pls_pkg::sts_t sts_i,
  output pls_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;

  // Output register can take a new result this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  assign cmd_o.exec      = accept;
  assign cmd_o.dump_step = (state_q == ST_DUMP) && out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && sts_i.dump_more) state_d = ST_DUMP;
      end
      ST_DUMP: begin
        if (cmd_o.dump_step && sts_i.dump_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output valid: set on a new result, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec || cmd_o.dump_step) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hw/rtl/pls_datapath.sv
// ------------------------------------------------------------------------
// pls_datapath
// Shift-chain element store, count, dump counter and result register.
// ------------------------------------------------------------------------
module pls_datapath #(
  parameter int unsigned CAPACITY = pls_pkg::CAPACITY_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pls_pkg::in_t  in_data_i,
  input  pls_pkg::cmd_t cmd_i,
  output pls_pkg::sts_t sts_o,
  output pls_pkg::out_t out_data_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [pls_pkg::DATA_W-1:0] cell_q [CAPACITY];
  logic [pls_pkg::DATA_W-1:0] prev_w [CAPACITY];
  logic [pls_pkg::DATA_W-1:0] next_w [CAPACITY];

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] ipos, rpos;
  logic          do_ins, do_rem, do_rot;
  logic          pneg, full, empty;
  logic          pos_ok_ins, pos_ok_rem;
  logic [pls_pkg::POS_W-1:0] pos8, cnt8;

  pls_pkg::out_t out_q, out_d;
  logic [1:0]    res_status;
  logic [pls_pkg::DATA_W-1:0] res_elem;
  logic          res_last;

  // Position checks
  assign pneg       = in_data_i.position[pls_pkg::POS_W-1];
  assign pos8       = in_data_i.position;
  assign cnt8       = pls_pkg::POS_W'(cnt_q);
  assign pos_ok_ins = !pneg && (pos8 <= cnt8);
  assign pos_ok_rem = !pneg && (pos8 < cnt8);
  assign full       = (cnt_q == CW'(CAPACITY));
  assign empty      = (cnt_q == '0);
  assign cnt_m1     = cnt_q - CW'(1);

  // Status to controller
  assign sts_o.dump_more = (in_data_i.op == pls_pkg::OP_DUMP) && (cnt_q > CW'(1));
  assign sts_o.dump_last = (rem_q == CW'(1));

  // Operation decode and result
  always_comb begin
    res_status = pls_pkg::STS_OK;
    res_elem   = '0;
    res_last   = 1'b1;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    do_rot     = 1'b0;
    ipos       = '0;
    rpos       = '0;
    if (cmd_i.exec) begin
      unique case (in_data_i.op) inside
        pls_pkg::OP_INS_FRONT, pls_pkg::OP_INS_BACK: begin
          if (full) begin
            res_status = pls_pkg::STS_FULL;
          end else begin
            do_ins = 1'b1;
            ipos   = (in_data_i.op == pls_pkg::OP_INS_BACK) ? cnt_q : '0;
            cnt_d  = cnt_q + CW'(1);
          end
        end
        pls_pkg::OP_INS_AT: begin
          if (!pos_ok_ins) begin
            res_status = pls_pkg::STS_RANGE;
          end else if (full) begin
            res_status = pls_pkg::STS_FULL;
          end else begin
            do_ins = 1'b1;
            ipos   = CW'(pos8);
            cnt_d  = cnt_q + CW'(1);
          end
        end
        pls_pkg::OP_REM_FRONT, pls_pkg::OP_REM_BACK: begin
          if (empty) begin
            res_status = pls_pkg::STS_EMPTY;
          end else begin
            do_rem = 1'b1;
            rpos   = (in_data_i.op == pls_pkg::OP_REM_BACK) ? cnt_m1 : '0;
            cnt_d  = cnt_m1;
          end
        end
        pls_pkg::OP_REM_AT: begin
          if (empty) begin
            res_status = pls_pkg::STS_EMPTY;
          end else if (!pos_ok_rem) begin
            res_status = pls_pkg::STS_RANGE;
          end else begin
            do_rem = 1'b1;
            rpos   = CW'(pos8);
            cnt_d  = cnt_m1;
          end
        end
        pls_pkg::OP_DUMP: begin
          if (empty) begin
            res_status = pls_pkg::STS_EMPTY;
          end else begin
            res_elem = cell_q[0];
            res_last = (cnt_q == CW'(1));
            do_rot   = 1'b1;
            rem_d    = cnt_m1;
          end
        end
        default: ;  // unused opcode: no change
      endcase
    end else if (cmd_i.dump_step) begin
      res_elem = cell_q[0];
      res_last = (rem_q == CW'(1));
      do_rot   = 1'b1;
      rem_d    = rem_q - CW'(1);
    end
  end

  always_comb begin
    out_d          = out_q;
    out_d.status   = res_status;
    out_d.element  = res_elem;
    out_d.count    = pls_pkg::CNT_W'(cnt_d);
    out_d.is_empty = (cnt_d == '0);
    out_d.last     = res_last;
  end

  // Neighbor taps of the chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_tap
    if (i == 0) begin : g_first
      assign prev_w[i] = '0;
    end else begin : g_prev
      assign prev_w[i] = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign next_w[i] = cell_q[i];
    end else begin : g_next
      assign next_w[i] = cell_q[i+1];
    end
  end

  // Shift chain cells: insert shifts up, remove and dump rotation shift down
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (do_ins) begin
        if (CW'(i) == ipos) begin
          cell_q[i] <= in_data_i.value;
        end else if (CW'(i) > ipos) begin
          cell_q[i] <= prev_w[i];
        end
      end else if (do_rem) begin
        if (CW'(i) >= rpos) cell_q[i] <= next_w[i];
      end else if (do_rot) begin
        if (CW'(i) == cnt_m1) begin
          cell_q[i] <= cell_q[0];
        end else if (CW'(i) < cnt_m1) begin
          cell_q[i] <= next_w[i];
        end
      end
    end
  end

  // Count and dump counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rem_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      rem_q <= rem_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec || cmd_i.dump_step) out_q <= out_d;
  end

  assign out_data_o = out_q;

endmodule

// File: hw/rtl/positional_list_store.sv
// ------------------------------------------------------------------------
// positional_list_store
// Ordered list of signed 32-bit values with positional insert/remove
// and an in-order dump, held in a shift chain.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o  | pls_pkg::in_t
//   out     | output    | out_valid_o / out_stall_i | pls_pkg::out_t
//
// Insert and remove finish in the cycle of the transfer; the result is
// registered and visible the next cycle. A dump gives one result per
// cycle unless the output stalls, rotating the chain one cell a step.
// A new input is taken when no dump runs and the result register is
// free or being taken. Reset empties the list; cells are not cleared.
// ------------------------------------------------------------------------
module positional_list_store #(
  parameter int unsigned CAPACITY = pls_pkg::CAPACITY_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pls_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pls_pkg::out_t out_data_o
);

  pls_pkg::cmd_t cmd;
  pls_pkg::sts_t sts;

  pls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pls_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

// File: hw/rtl/pls_checker.sv
// ------------------------------------------------------------------------
// pls_checker
// Port-level assertions for the positional list store.
// ------------------------------------------------------------------------
`include "positional_list_store_macros.svh"

module pls_checker #(
  parameter int unsigned CAPACITY = pls_pkg::CAPACITY_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input pls_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input pls_pkg::out_t out_data_o
);

  logic err_res;
  logic err_ok;
  logic out_held;
  logic cnt_zero;
  logic cnt_ok;
  logic single_in;

  assign err_res   = (out_data_o.status != pls_pkg::STS_OK);
  assign err_ok    = out_data_o.last && (out_data_o.element == '0);
  assign out_held  = out_valid_o && out_stall_i;
  assign cnt_zero  = (out_data_o.count == '0);
  assign cnt_ok    = (out_data_o.count <= pls_pkg::CNT_W'(CAPACITY));
  assign single_in = in_valid_i && !in_stall_o && (in_data_i.op != pls_pkg::OP_DUMP);

  // A stalled result holds
  `PLS_ASSERT_NXT(a_out_hold, out_held, out_valid_o && $stable(out_data_o), "stalled result changed")

  // Empty flag follows the count
  `PLS_ASSERT_IMP(a_empty_flag, out_valid_o, out_data_o.is_empty == cnt_zero, "is_empty wrong")

  // Count never exceeds capacity
  `PLS_ASSERT_IMP(a_count_cap, out_valid_o, cnt_ok, "count above capacity")

  // Error results are single, final and carry no element
  `PLS_ASSERT_IMP(a_err_last, out_valid_o && err_res, err_ok, "error result not final or nonzero")

  // A non-dump input transfer gives one final result next cycle
  `PLS_ASSERT_NXT(a_single_res, single_in, out_valid_o && out_data_o.last, "no final result")

endmodule

bind positional_list_store pls_checker #(.CAPACITY(CAPACITY)) u_pls_checker (.*);
